>>> hdl/thp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and rounding helpers for the tapered helix evaluator.
// No dependencies; imported by every module of the block.
package thp_pkg;

  // CORDIC length; the datapath stops at 32 steps
  localparam int CORDIC_ITER = 24;
  localparam int NUM_STEPS   = (CORDIC_ITER < 32) ? CORDIC_ITER : 32;

  // |t| * 64 in Q.30 needs 38 bits; CORDIC words carry two guard bits
  localparam int ANG_W  = 38;
  localparam int CW     = 34;
  localparam int PROD_W = 96;

  localparam logic [ANG_W-1:0] TWO_PI_Q30  = 38'd6746518852;
  localparam logic [ANG_W-1:0] PI_Q30      = 38'd3373259426;
  localparam logic [ANG_W-1:0] HALF_PI_Q30 = 38'd1686629713;
  localparam logic [CW-1:0]    INV_GAIN_Q30 = 34'd652032874;
  localparam logic [31:0]      INV_TWO_PI_Q32 = 32'd683565276;

  // arctan(2^-i), truncated to Q.30
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_START_RADIUS  = 3'd0,
    REG_HELIX_PITCH   = 3'd1,
    REG_TAPER_TANGENT = 3'd2,
    REG_CLOCKWISE     = 3'd3
  } thp_reg_e;

  // magnitude rounded half up at bit position sh
  function automatic logic [PROD_W-1:0] rnd_shr(input logic [PROD_W-1:0] p,
                                                input int unsigned sh);
    logic [PROD_W-1:0] half;
    half = PROD_W'(1) << (sh - 1);
    return (p + half) >> sh;
  endfunction

  // sign applied to a rounded magnitude, two's complement result
  function automatic logic [63:0] apply_sign(input logic [PROD_W-1:0] mag, input logic neg);
    logic [63:0] m;
    m = mag[63:0];
    return neg ? (~m + 64'd1) : m;
  endfunction

  // Q.32 to Q16.16, half away from zero
  function automatic logic [63:0] rnd16(input logic [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? (~v + 64'd1) : v;
    r = (m + 64'd32768) >> 16;
    return v[63] ? (~r + 64'd1) : r;
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] v);
    logic signed [63:0] s;
    s = $signed(v);
    if (s > 64'sd2147483647) begin
      return 32'h7FFFFFFF;
    end else if (s < -64'sd2147483648) begin
      return 32'h80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

>>> hdl/tapered_helix_point_eval.sv
`timescale 1ns / 1ps
// Tapered helix evaluator: point, first and second derivative at angle t.
// Results pass the CORDIC stage chain and then the multiply and rounding stages behind it.
// Throughput: one item per cycle; busy_o stays low and results cannot be held off.
// Reset clears all valid bits and loads the register defaults (radius 1.0, pitch 1.0,
// taper 0, clockwise); the rise and slope derived from a write pass through registers.
module tapered_helix_point_eval import thp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] angle_param_i,
  output logic        done_o,
  output logic [31:0] point_x_o,
  output logic [31:0] point_y_o,
  output logic [31:0] point_z_o,
  output logic [31:0] tangent_x_o,
  output logic [31:0] tangent_y_o,
  output logic [31:0] tangent_z_o,
  output logic [31:0] curvature_x_o,
  output logic [31:0] curvature_y_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int LAT = NUM_STEPS + 14;

  logic [31:0] start_radius_q, helix_pitch_q, taper_tangent_q;
  logic        clockwise_q;

  logic [63:0]       rise_q, slope_q;
  logic [31:0]       tz_q, tap_abs;
  logic [PROD_W-1:0] slope_prod;
  logic              slope_neg;

  logic        cor_vld;
  logic [31:0] cor_t, cor_cos, cor_sin, t_abs;

  logic [7:0]  pv_q;
  logic [31:0] c_d1_q, c_d2_q, c_d3_q, s_d1_q, s_d2_q, s_d3_q;
  logic [63:0] slope_abs, rad_q, rad_abs;
  logic [31:0] c_abs, s_abs;

  logic [PROD_W-1:0] rt_prod, zt_prod, rc_prod, rs_prod, kc_prod, ks_prod;
  logic              rt_neg, zt_neg, rc_neg, rs_neg, kc_neg, ks_neg;

  logic [31:0] pz_q [5];
  logic [63:0] rc30_q, rc46_q, rs30_q, rs46_q, kc30_q, kc29_q, ks30_q, ks29_q;
  logic [63:0] tx_q, ty_q, cx_q, cy_q;
  logic [31:0] px_q, py_q;
  logic [63:0] ty_r, cy_r;

  logic        done_q;
  logic [31:0] point_x_q, point_y_q, point_z_q, tangent_x_q, tangent_y_q, tangent_z_q;
  logic [31:0] curvature_x_q, curvature_y_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_radius_q  <= 32'd65536;
      helix_pitch_q   <= 32'd65536;
      taper_tangent_q <= 32'd0;
      clockwise_q     <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_START_RADIUS:  start_radius_q  <= cfg_data_i;
        REG_HELIX_PITCH:   helix_pitch_q   <= cfg_data_i;
        REG_TAPER_TANGENT: taper_tangent_q <= cfg_data_i;
        REG_CLOCKWISE:     clockwise_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // rise (Q.48), slope (Q.32) and axial derivative from the registers
  assign tap_abs = taper_tangent_q[31] ? (~taper_tangent_q + 32'd1) : taper_tangent_q;

  always_ff @(posedge clk_i) begin
    rise_q <= {32'd0, helix_pitch_q} * {32'd0, INV_TWO_PI_Q32};
  end

  thp_mul u_slope_mul (
    .clk_i   (clk_i),
    .a_mag_i (rise_q),
    .b_mag_i (tap_abs),
    .neg_i   (taper_tangent_q[31]),
    .prod_o  (slope_prod),
    .neg_o   (slope_neg)
  );

  always_ff @(posedge clk_i) begin
    slope_q <= apply_sign(rnd_shr(slope_prod, 48), slope_neg);
    tz_q    <= 32'((rise_q + 64'h80000000) >> 32);
  end

  // sine and cosine
  thp_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i && !busy_o),
    .t_i    (angle_param_i),
    .vld_o  (cor_vld),
    .t_o    (cor_t),
    .cos_o  (cor_cos),
    .sin_o  (cor_sin)
  );

  // radius and axial products
  assign t_abs     = cor_t[31] ? (~cor_t + 32'd1) : cor_t;
  assign slope_abs = slope_q[63] ? (~slope_q + 64'd1) : slope_q;

  thp_mul u_rad_mul (
    .clk_i   (clk_i),
    .a_mag_i (slope_abs),
    .b_mag_i (t_abs),
    .neg_i   (slope_q[63] ^ cor_t[31]),
    .prod_o  (rt_prod),
    .neg_o   (rt_neg)
  );

  thp_mul u_z_mul (
    .clk_i   (clk_i),
    .a_mag_i (rise_q),
    .b_mag_i (t_abs),
    .neg_i   (cor_t[31]),
    .prod_o  (zt_prod),
    .neg_o   (zt_neg)
  );

  always_ff @(posedge clk_i) begin
    c_d1_q <= cor_cos;
    c_d2_q <= c_d1_q;
    c_d3_q <= c_d2_q;
    s_d1_q <= cor_sin;
    s_d2_q <= s_d1_q;
    s_d3_q <= s_d2_q;
    rad_q  <= {16'd0, start_radius_q, 16'd0} + apply_sign(rnd_shr(rt_prod, 24), rt_neg);
    pz_q[0] <= sat32(apply_sign(rnd_shr(zt_prod, 56), zt_neg));
    for (int k = 1; k < 5; k++) begin
      pz_q[k] <= pz_q[k-1];
    end
  end

  // trig products
  assign rad_abs = rad_q[63] ? (~rad_q + 64'd1) : rad_q;
  assign c_abs   = c_d3_q[31] ? (~c_d3_q + 32'd1) : c_d3_q;
  assign s_abs   = s_d3_q[31] ? (~s_d3_q + 32'd1) : s_d3_q;

  thp_mul u_rc_mul (
    .clk_i (clk_i), .a_mag_i (rad_abs), .b_mag_i (c_abs),
    .neg_i (rad_q[63] ^ c_d3_q[31]), .prod_o (rc_prod), .neg_o (rc_neg)
  );

  thp_mul u_rs_mul (
    .clk_i (clk_i), .a_mag_i (rad_abs), .b_mag_i (s_abs),
    .neg_i (rad_q[63] ^ s_d3_q[31]), .prod_o (rs_prod), .neg_o (rs_neg)
  );

  thp_mul u_kc_mul (
    .clk_i (clk_i), .a_mag_i (slope_abs), .b_mag_i (c_abs),
    .neg_i (slope_q[63] ^ c_d3_q[31]), .prod_o (kc_prod), .neg_o (kc_neg)
  );

  thp_mul u_ks_mul (
    .clk_i (clk_i), .a_mag_i (slope_abs), .b_mag_i (s_abs),
    .neg_i (slope_q[63] ^ s_d3_q[31]), .prod_o (ks_prod), .neg_o (ks_neg)
  );

  // rounded terms; shift 29 gives the doubled slope terms
  always_ff @(posedge clk_i) begin
    rc30_q <= apply_sign(rnd_shr(rc_prod, 30), rc_neg);
    rc46_q <= apply_sign(rnd_shr(rc_prod, 46), rc_neg);
    rs30_q <= apply_sign(rnd_shr(rs_prod, 30), rs_neg);
    rs46_q <= apply_sign(rnd_shr(rs_prod, 46), rs_neg);
    kc30_q <= apply_sign(rnd_shr(kc_prod, 30), kc_neg);
    kc29_q <= apply_sign(rnd_shr(kc_prod, 29), kc_neg);
    ks30_q <= apply_sign(rnd_shr(ks_prod, 30), ks_neg);
    ks29_q <= apply_sign(rnd_shr(ks_prod, 29), ks_neg);
  end

  // derivative sums and point coordinates
  always_ff @(posedge clk_i) begin
    tx_q <= kc30_q - rs30_q;
    ty_q <= ks30_q + rc30_q;
    cx_q <= (~rc30_q + 64'd1) - ks29_q;
    cy_q <= kc29_q - rs30_q;
    px_q <= sat32(rc46_q);
    py_q <= sat32(clockwise_q ? rs46_q : (~rs46_q + 64'd1));
  end

  // final rounding, winding sign and saturation
  always_comb begin
    ty_r = rnd16(ty_q);
    cy_r = rnd16(cy_q);
    if (!clockwise_q) begin
      ty_r = ~ty_r + 64'd1;
      cy_r = ~cy_r + 64'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    point_x_q     <= px_q;
    point_y_q     <= py_q;
    point_z_q     <= pz_q[4];
    tangent_x_q   <= sat32(rnd16(tx_q));
    tangent_y_q   <= sat32(ty_r);
    tangent_z_q   <= tz_q;
    curvature_x_q <= sat32(rnd16(cx_q));
    curvature_y_q <= sat32(cy_r);
  end

  // valid bits behind the CORDIC
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= '0;
      done_q <= 1'b0;
    end else begin
      pv_q   <= {pv_q[6:0], cor_vld};
      done_q <= pv_q[6];
    end
  end

  assign done_o        = done_q;
  assign point_x_o     = point_x_q;
  assign point_y_o     = point_y_q;
  assign point_z_o     = point_z_q;
  assign tangent_x_o   = tangent_x_q;
  assign tangent_y_o   = tangent_y_q;
  assign tangent_z_o   = tangent_z_q;
  assign curvature_x_o = curvature_x_q;
  assign curvature_y_o = curvature_y_q;

  // every start beat yields a result beat at fixed latency
  a_fwd_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("start beat without result beat");

  // no result beat without a start beat
  a_back_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result beat without start beat");

  // pitch/2pi stays below 2^14 in Q16.16
  a_rise_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (tangent_z_o[31:30] == 2'b00))
    else $error("axial derivative out of range");

endmodule

>>> hdl/thp_mul.sv
`timescale 1ns / 1ps
// Two-stage 64x32 magnitude multiplier built from two 32x32 partial products.
// Depends on thp_pkg for the product width.
module thp_mul import thp_pkg::*; (
  input  logic              clk_i,
  input  logic [63:0]       a_mag_i,
  input  logic [31:0]       b_mag_i,
  input  logic              neg_i,
  output logic [PROD_W-1:0] prod_o,
  output logic              neg_o
);

  logic [63:0]       lo_q, hi_q;
  logic              neg1_q, neg2_q;
  logic [PROD_W-1:0] prod_q;

  // stage 1: partial products
  always_ff @(posedge clk_i) begin
    lo_q   <= {32'd0, a_mag_i[31:0]} * {32'd0, b_mag_i};
    hi_q   <= {32'd0, a_mag_i[63:32]} * {32'd0, b_mag_i};
    neg1_q <= neg_i;
  end

  // stage 2: combine
  always_ff @(posedge clk_i) begin
    prod_q <= {hi_q, 32'd0} + {32'd0, lo_q};
    neg2_q <= neg1_q;
  end

  assign prod_o = prod_q;
  assign neg_o  = neg2_q;

endmodule

>>> hdl/thp_cordic.sv
`timescale 1ns / 1ps
// Angle reduction and pipelined rotation-mode CORDIC, one step per stage.
// Depends on thp_pkg for angle constants, the arctan table and the step count.
module thp_cordic import thp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  logic [31:0] t_i,
  output logic        vld_o,
  output logic [31:0] t_o,
  output logic [31:0] cos_o,
  output logic [31:0] sin_o
);

  localparam logic [ANG_W-1:0] TWO_PI_X16 = TWO_PI_Q30 << 4;
  localparam logic [ANG_W-1:0] TWO_PI_X8  = TWO_PI_Q30 << 3;
  localparam logic [ANG_W-1:0] TWO_PI_X4  = TWO_PI_Q30 << 2;
  localparam logic [ANG_W-1:0] TWO_PI_X2  = TWO_PI_Q30 << 1;
  localparam logic signed [CW-1:0] HALF_S = CW'(HALF_PI_Q30);
  localparam logic signed [31:0]   OUT_BOUND = 32'sd1073745920;

  function automatic logic [ANG_W-1:0] fold_sub(input logic [ANG_W-1:0] r,
                                                input logic [ANG_W-1:0] k);
    return (r >= k) ? (r - k) : r;
  endfunction

  logic             r1_vld_q, r2_vld_q, r3_vld_q, r4_vld_q;
  logic [ANG_W-1:0] r1_mag_q, r2_mag_q, r3_mag_q, r4_mag_q;
  logic             r1_neg_q, r2_neg_q, r3_neg_q, r4_neg_q;
  logic [31:0]      r1_t_q, r2_t_q, r3_t_q, r4_t_q;

  logic [31:0]      t_abs;
  logic [ANG_W-1:0] r2_mag_d, r3_mag_d, r4_mag_d, r5_mag_d;
  logic             r4_neg_d, r5_neg_d, r5_flip_d;
  logic signed [CW-1:0] z0_d;

  logic                 cv_q [NUM_STEPS+1];
  logic signed [CW-1:0] x_q  [NUM_STEPS+1];
  logic signed [CW-1:0] y_q  [NUM_STEPS+1];
  logic signed [CW-1:0] z_q  [NUM_STEPS+1];
  logic                 f_q  [NUM_STEPS+1];
  logic [31:0]          ct_q [NUM_STEPS+1];

  logic        out_vld_q;
  logic [31:0] out_t_q, cos_q, sin_q;

  // reduction: |t|*64 mod 2pi by binary subtraction, then fold to +-pi/2
  always_comb begin
    t_abs    = t_i[31] ? (~t_i + 32'd1) : t_i;
    r2_mag_d = fold_sub(fold_sub(fold_sub(r1_mag_q, TWO_PI_X16), TWO_PI_X8), TWO_PI_X4);
    r3_mag_d = fold_sub(fold_sub(r2_mag_q, TWO_PI_X2), TWO_PI_Q30);
    if (r3_mag_q > PI_Q30) begin
      r4_mag_d = TWO_PI_Q30 - r3_mag_q;
      r4_neg_d = ~r3_neg_q;
    end else begin
      r4_mag_d = r3_mag_q;
      r4_neg_d = r3_neg_q;
    end
    if (r4_mag_q > HALF_PI_Q30) begin
      r5_mag_d  = PI_Q30 - r4_mag_q;
      r5_neg_d  = ~r4_neg_q;
      r5_flip_d = 1'b1;
    end else begin
      r5_mag_d  = r4_mag_q;
      r5_neg_d  = r4_neg_q;
      r5_flip_d = 1'b0;
    end
    z0_d = r5_neg_d ? -$signed(CW'(r5_mag_d)) : $signed(CW'(r5_mag_d));
  end

  // reduction stage payload
  always_ff @(posedge clk_i) begin
    r1_mag_q <= {t_abs, 6'd0};
    r1_neg_q <= t_i[31];
    r1_t_q   <= t_i;
    r2_mag_q <= r2_mag_d;
    r2_neg_q <= r1_neg_q;
    r2_t_q   <= r1_t_q;
    r3_mag_q <= r3_mag_d;
    r3_neg_q <= r2_neg_q;
    r3_t_q   <= r2_t_q;
    r4_mag_q <= r4_mag_d;
    r4_neg_q <= r4_neg_d;
    r4_t_q   <= r3_t_q;
    x_q[0]   <= $signed(INV_GAIN_Q30);
    y_q[0]   <= '0;
    z_q[0]   <= z0_d;
    f_q[0]   <= r5_flip_d;
    ct_q[0]  <= r4_t_q;
  end

  // reduction stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q <= 1'b0;
      r2_vld_q <= 1'b0;
      r3_vld_q <= 1'b0;
      r4_vld_q <= 1'b0;
      cv_q[0]  <= 1'b0;
    end else begin
      r1_vld_q <= vld_i;
      r2_vld_q <= r1_vld_q;
      r3_vld_q <= r2_vld_q;
      r4_vld_q <= r3_vld_q;
      cv_q[0]  <= r4_vld_q;
    end
  end

  // one rotation per stage
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    logic signed [CW-1:0] dx, dy, ang;
    assign dx  = y_q[i] >>> i;
    assign dy  = x_q[i] >>> i;
    assign ang = CW'(ATAN_Q30[i]);

    always_ff @(posedge clk_i) begin
      if (!z_q[i][CW-1]) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - ang;
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + ang;
      end
      f_q[i+1]  <= f_q[i];
      ct_q[i+1] <= ct_q[i];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else begin
        cv_q[i+1] <= cv_q[i];
      end
    end
  end

  // quadrant restore
  always_ff @(posedge clk_i) begin
    cos_q   <= f_q[NUM_STEPS] ? 32'(-x_q[NUM_STEPS]) : 32'(x_q[NUM_STEPS]);
    sin_q   <= f_q[NUM_STEPS] ? 32'(-y_q[NUM_STEPS]) : 32'(y_q[NUM_STEPS]);
    out_t_q <= ct_q[NUM_STEPS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= cv_q[NUM_STEPS];
    end
  end

  assign vld_o = out_vld_q;
  assign t_o   = out_t_q;
  assign cos_o = cos_q;
  assign sin_o = sin_q;

  // folded angle stays within the CORDIC convergence range
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_q[0] |-> (z_q[0] <= HALF_S) && (z_q[0] >= -HALF_S))
    else $error("folded angle beyond pi/2");

  // unit vector result
  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> ($signed(cos_o) <= OUT_BOUND) && ($signed(cos_o) >= -OUT_BOUND) &&
              ($signed(sin_o) <= OUT_BOUND) && ($signed(sin_o) >= -OUT_BOUND))
    else $error("sine or cosine out of range");

  // each result beat traces back to an input beat at fixed depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> $past(vld_i, NUM_STEPS + 6))
    else $error("cordic result without matching input");

endmodule

>>> tb/sv/tb_tapered_helix_point_eval.sv
`timescale 1ns / 1ps
// Self-checking testbench for tapered_helix_point_eval: directed and random angles
// under many register settings, checked against a built-in fixed-point helix predictor.
// Depends on thp_pkg and the tapered_helix_point_eval RTL.
module tb_tapered_helix_point_eval;
  import thp_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 50;
  localparam int          SETTLE_CYCLES  = 6;
  localparam logic [2:0]  REG_SPARE_LO   = 3'd4;
  localparam logic [2:0]  REG_SPARE_HI   = 3'd7;
  // angles in Q8.24
  localparam logic [31:0] T_HALF_PI      = 32'd26353589;
  localparam logic [31:0] T_PI           = 32'd52707179;
  localparam logic [31:0] T_TWO_PI       = 32'd105414357;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [31:0] angle_param_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        busy_o, done_o, cfg_ready_o;
  logic [31:0] point_x_o, point_y_o, point_z_o, tangent_x_o, tangent_y_o, tangent_z_o;
  logic [31:0] curvature_x_o, curvature_y_o;

  // predictor copy of the registers
  logic [31:0] radius_q = 32'h0001_0000;
  logic [31:0] pitch_q = 32'h0001_0000;
  logic [31:0] taper_q = '0;
  logic        cw_q = 1'b1;

  logic [7:0][31:0] helix_expected_q[$];
  int n_mismatch = 0;
  int n_items = 0;
  int n_results = 0;
  int n_cfg = 0;
  int idle_cycles = 0;
  bit no_gaps = 0;

  always #5 clk_i = ~clk_i;

  tapered_helix_point_eval u_top (.*);

  // round(a*b / 2^sh) half away from zero, saturated to int64
  function automatic longint mul_rnd(longint a, longint b, int sh);
    logic         neg;
    logic [63:0]  ua, ub;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'b0, ua} * {64'b0, ub};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // rotation-mode CORDIC with quadrant fold
  function automatic void helix_sincos(longint t, output longint cs, output longint sn);
    longint z, x, y, dx, dy;
    bit     flip;
    z = (t * 64) % longint'(TWO_PI_Q30);
    x = longint'(INV_GAIN_Q30);
    y = 0;
    flip = 0;
    if (z > longint'(PI_Q30)) z -= longint'(TWO_PI_Q30);
    if (z < -longint'(PI_Q30)) z += longint'(TWO_PI_Q30);
    if (z > longint'(HALF_PI_Q30)) begin
      z -= longint'(PI_Q30);
      flip = 1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z += longint'(PI_Q30);
      flip = 1;
    end
    for (int i = 0; i < NUM_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_Q30[i]);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  // point, tangent and curvature of the helix at one angle
  function automatic logic [7:0][31:0] helix_eval(logic [31:0] angle);
    longint t, rise, slope, rad, c, s, tx, ty, cx, cy, py;
    logic [7:0][31:0] r;
    t = longint'($signed(angle));
    rise = longint'(64'(pitch_q) * 64'(INV_TWO_PI_Q32));
    slope = mul_rnd(rise, longint'($signed(taper_q)), 48);
    rad = longint'({16'b0, radius_q, 16'b0}) + mul_rnd(slope, t, 24);
    helix_sincos(t, c, s);
    tx = mul_rnd(slope, c, 30) - mul_rnd(rad, s, 30);
    ty = mul_rnd(slope, s, 30) + mul_rnd(rad, c, 30);
    cx = -mul_rnd(rad, c, 30) - mul_rnd(2 * slope, s, 30);
    cy = mul_rnd(2 * slope, c, 30) - mul_rnd(rad, s, 30);
    py = mul_rnd(rad, s, 46);
    ty = mul_rnd(ty, 1, 16);
    cy = mul_rnd(cy, 1, 16);
    if (!cw_q) begin
      py = -py;
      ty = -ty;
      cy = -cy;
    end
    r[0] = clamp32(mul_rnd(rad, c, 46));
    r[1] = clamp32(py);
    r[2] = clamp32(mul_rnd(rise, t, 56));
    r[3] = clamp32(mul_rnd(tx, 1, 16));
    r[4] = clamp32(ty);
    r[5] = clamp32(mul_rnd(rise, 1, 32));
    r[6] = clamp32(mul_rnd(cx, 1, 16));
    r[7] = clamp32(cy);
    return r;
  endfunction

  // mostly back to back or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one angle beat; start stays high for a following beat
  task automatic send_angle(logic [31:0] angle);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    angle_param_i <= angle;
    do @(posedge clk_i); while (busy_o);
    helix_expected_q.push_back(helix_eval(angle));
    n_items++;
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (helix_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // register write; only called with the pipeline empty
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_START_RADIUS:  radius_q = data;
      REG_HELIX_PITCH:   pitch_q = data;
      REG_TAPER_TANGENT: taper_q = data;
      REG_CLOCKWISE:     cw_q = data[0];
      default: ;
    endcase
    n_cfg++;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_angle();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
  endfunction

  // result beat checker
  always @(posedge clk_i) begin
    logic [7:0][31:0] got, want;
    got = {curvature_y_o, curvature_x_o, tangent_z_o, tangent_y_o,
           tangent_x_o, point_z_o, point_y_o, point_x_o};
    if (rst_ni && done_o) begin
      n_results++;
      if (helix_expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        n_mismatch++;
      end else begin
        want = helix_expected_q.pop_front();
        for (int f = 0; f < 8; f++) begin
          if (got[f] !== want[f]) begin
            $display("%0t: field %0d expected %h actual %h", $time, f, want[f], got[f]);
            n_mismatch++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat of any kind
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // defaults: zero, extremes, quadrant edges, alternating bits
  task automatic test_reset_defaults();
    logic [31:0] angles[12];
    angles = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, T_HALF_PI, -T_HALF_PI, T_PI, -T_PI,
               T_TWO_PI, 32'd1, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    foreach (angles[i]) send_angle(angles[i]);
  endtask

  // every register at its extremes, plus writes to spare indexes
  task automatic test_register_extremes();
    write_reg(REG_START_RADIUS, 32'hFFFF_FFFF);
    write_reg(REG_HELIX_PITCH, 32'hFFFF_FFFF);
    write_reg(REG_TAPER_TANGENT, 32'h7FFF_FFFF);
    write_reg(REG_CLOCKWISE, 32'd0);
    send_angle(T_HALF_PI);
    send_angle(32'h8000_0000);
    write_reg(REG_TAPER_TANGENT, 32'h8000_0000);
    send_angle(32'h7FFF_FFFF);
    send_angle(-T_PI);
    write_reg(REG_START_RADIUS, 32'd0);
    write_reg(REG_HELIX_PITCH, 32'd0);
    write_reg(REG_TAPER_TANGENT, 32'd0);
    send_angle(T_PI);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h1234_5678);
    write_reg(REG_CLOCKWISE, 32'hFFFF_FFFE);
    send_angle(T_HALF_PI);
    write_reg(REG_START_RADIUS, 32'h0003_0000);
    write_reg(REG_HELIX_PITCH, 32'h0002_0000);
    write_reg(REG_TAPER_TANGENT, 32'h0040_0000);
    write_reg(REG_CLOCKWISE, 32'd1);
    send_angle(-T_HALF_PI);
    send_angle(T_TWO_PI);
  endtask

  // random phases, each under a fresh register setting
  task automatic test_random_sweep();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_START_RADIUS, ($urandom_range(0, 4) == 0) ? $urandom()
                                                              : $urandom_range(0, 32'h0100_0000));
      write_reg(REG_HELIX_PITCH, ($urandom_range(0, 4) == 0) ? $urandom()
                                                             : $urandom_range(0, 32'h0040_0000));
      write_reg(REG_TAPER_TANGENT, ($urandom_range(0, 3) == 0) ? $urandom()
                : 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000));
      write_reg(REG_CLOCKWISE, $urandom());
      no_gaps = (ph % 3 == 1);
      for (int i = 0; i < 210; i++) begin
        // hold off once until the pipeline is empty
        if (ph == 2 && i == 100) wait_drained();
        send_angle(rand_angle());
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_random_sweep();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d angle beats, %0d results, %0d register writes",
             n_items, n_results, n_cfg);
    $display("settings swept: extremes, spare indexes, both windings, random phases");
    if (n_mismatch == 0 && helix_expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
